// ===== sv/itbl_pkg.sv =====
// ----------------------------------------------------------------------------
// itbl_pkg
// Shared types and constants of the innovation table: sizes, op and status
// codes, the stored record and the memory request bundle.
// ----------------------------------------------------------------------------
package itbl_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ID_BITS     = 24;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

	localparam logic [3:0] OP_FIRST      = 4'd0;
	localparam logic [3:0] OP_LAST       = 4'd1;
	localparam logic [3:0] OP_ALL_IDX    = 4'd2;
	localparam logic [3:0] OP_FIRST_NRN  = 4'd3;
	localparam logic [3:0] OP_LAST_NRN   = 4'd4;
	localparam logic [3:0] OP_ADD_LINK   = 4'd5;
	localparam logic [3:0] OP_ADD_NEURON = 4'd6;
	localparam logic [3:0] OP_INIT       = 4'd7;
	localparam logic [3:0] OP_FLUSH      = 4'd8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic REG_START_INNOV  = 1'b0;
	localparam logic REG_START_NEURON = 1'b1;

	typedef struct packed {
		logic [ID_BITS-1:0] from_id;
		logic [ID_BITS-1:0] to_id;
		logic               is_neuron;
		logic [ID_BITS-1:0] innovation;
		logic [ID_BITS-1:0] neuron;
		logic [2:0]         neuron_kind;
	} rec_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [ID_BITS-1:0] start_innovation;
		logic [ID_BITS-1:0] start_neuron;
	} cfg_regs_t;

endpackage

// ===== sv/itbl_mem.sv =====
// ----------------------------------------------------------------------------
// itbl_mem
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module itbl_mem (
	input  logic              clk,
	input  itbl_pkg::mem_req_t req,
	input  itbl_pkg::rec_t     wdata,
	output itbl_pkg::rec_t     rdata
);
	import itbl_pkg::*;

	rec_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== sv/itbl_cfg.sv =====
// ----------------------------------------------------------------------------
// itbl_cfg
// APB register file holding the start values loaded by init.
// ----------------------------------------------------------------------------
module itbl_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [itbl_pkg::PADDR_W-1:0]   paddr,
	input  logic [itbl_pkg::PDATA_W-1:0]   pwdata,
	output logic [itbl_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output itbl_pkg::cfg_regs_t            regs
);
	import itbl_pkg::*;

	logic [ID_BITS-1:0] start_innov_q;
	logic [ID_BITS-1:0] start_neuron_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_innov_q  <= ID_BITS'(1);
			start_neuron_q <= ID_BITS'(1);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_START_INNOV:  start_innov_q  <= pwdata[ID_BITS-1:0];
				REG_START_NEURON: start_neuron_q <= pwdata[ID_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_START_INNOV:  prdata = PDATA_W'(start_innov_q);
			REG_START_NEURON: prdata = PDATA_W'(start_neuron_q);
			default:          prdata = '0;
		endcase
	end

	assign regs.start_innovation = start_innov_q;
	assign regs.start_neuron     = start_neuron_q;

endmodule

// ===== sv/itbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// itbl_ctrl
// Sequencer: scans the record store one entry per cycle for lookups,
// appends records for adds, and keeps the record count and both counters.
// ----------------------------------------------------------------------------
module itbl_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [3:0]                  op,
	input  logic [itbl_pkg::ID_BITS-1:0] from_id,
	input  logic [itbl_pkg::ID_BITS-1:0] to_id,
	input  logic                        kind,
	input  logic [2:0]                  neuron_kind,
	output logic                        valid,
	output logic                        found,
	output logic [itbl_pkg::ID_BITS-1:0] value,
	output logic [1:0]                  status,
	output logic                        last,
	input  itbl_pkg::cfg_regs_t          regs,
	output itbl_pkg::mem_req_t           mem_req,
	output itbl_pkg::rec_t               mem_wdata,
	input  itbl_pkg::rec_t               mem_rdata
);
	import itbl_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH, S_EXEC} state_t;

	state_t             state_q;
	logic [3:0]         op_q;
	logic [ID_BITS-1:0] from_q;
	logic [ID_BITS-1:0] to_q;
	logic               want_q;
	logic [2:0]         nk_q;
	logic [IDX_W-1:0]   addr_q;
	logic               rv_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_q;
	logic [ID_BITS-1:0] val_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic [CNT_W-1:0]   rec_count_q;
	logic [ID_BITS-1:0] next_inn_q;
	logic [ID_BITS-1:0] next_neu_q;
	logic               valid_q;
	logic               found_q;
	logic [ID_BITS-1:0] value_q;
	logic [1:0]         status_q;
	logic               last_q;

	logic               accept;
	logic               is_lookup;
	logic               is_first;
	logic               is_innov;
	logic               match;
	logic [ID_BITS-1:0] rd_val;
	logic [CNT_W-1:0]   cnt_m1;
	logic               full;
	logic               sat;
	logic               add_ok;

	assign accept    = start & (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign is_lookup = (op == OP_FIRST) || (op == OP_LAST) || (op == OP_ALL_IDX)
		|| (op == OP_FIRST_NRN) || (op == OP_LAST_NRN);
	assign is_first  = (op_q == OP_FIRST) || (op_q == OP_FIRST_NRN);
	assign is_innov  = (op_q == OP_FIRST) || (op_q == OP_LAST);
	assign cnt_m1    = rec_count_q - CNT_W'(1);

	assign match  = rv_s1 && (mem_rdata.from_id == from_q) && (mem_rdata.to_id == to_q)
		&& (mem_rdata.is_neuron == want_q);
	assign rd_val = is_innov ? mem_rdata.innovation : mem_rdata.neuron;

	assign full   = (rec_count_q == CNT_W'(TABLE_DEPTH));
	assign sat    = (next_inn_q == ID_MAX) || ((op_q == OP_ADD_NEURON) && (next_neu_q == ID_MAX));
	assign add_ok = (state_q == S_EXEC) && ((op_q == OP_ADD_LINK) || (op_q == OP_ADD_NEURON))
		&& !full && !sat;

	always_comb begin
		mem_req.re    = (state_q == S_SCAN);
		mem_req.raddr = addr_q;
		mem_req.we    = add_ok;
		mem_req.waddr = rec_count_q[IDX_W-1:0];
		mem_wdata.from_id     = from_q;
		mem_wdata.to_id       = to_q;
		mem_wdata.is_neuron   = (op_q == OP_ADD_NEURON);
		mem_wdata.innovation  = next_inn_q;
		mem_wdata.neuron      = (op_q == OP_ADD_NEURON) ? next_neu_q : '0;
		mem_wdata.neuron_kind = (op_q == OP_ADD_NEURON) ? nk_q : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rv_s1       <= 1'b0;
			hit_q       <= 1'b0;
			pend_q      <= 1'b0;
			rec_count_q <= '0;
			next_inn_q  <= ID_BITS'(1);
			next_neu_q  <= ID_BITS'(1);
			valid_q     <= 1'b0;
			addr_q      <= '0;
		end else begin
			valid_q <= 1'b0;
			rv_s1   <= (state_q == S_SCAN);
			idx_s1  <= addr_q;

			// lookup result tracking, one stored entry per cycle
			if (match) begin
				hit_q <= 1'b1;
				if (!(is_first && hit_q)) begin
					val_q <= rd_val;
				end
				pend_q     <= 1'b1;
				pend_idx_q <= idx_s1;
				if (op_q == OP_ALL_IDX && pend_q) begin
					valid_q  <= 1'b1;
					found_q  <= 1'b1;
					value_q  <= ID_BITS'(pend_idx_q);
					status_q <= ST_OK;
					last_q   <= 1'b0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= op;
						from_q <= from_id;
						to_q   <= to_id;
						want_q <= (op == OP_FIRST_NRN || op == OP_LAST_NRN) ? 1'b1 : kind;
						nk_q   <= neuron_kind;
						addr_q <= '0;
						hit_q  <= 1'b0;
						pend_q <= 1'b0;
						val_q  <= '0;
						if (!is_lookup) begin
							state_q <= S_EXEC;
						end else if (rec_count_q == '0) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + IDX_W'(1);
					if ({1'b0, addr_q} == cnt_m1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					valid_q  <= 1'b1;
					status_q <= ST_OK;
					last_q   <= 1'b1;
					if (op_q == OP_ALL_IDX) begin
						found_q <= pend_q;
						value_q <= pend_q ? ID_BITS'(pend_idx_q) : '0;
					end else begin
						found_q <= hit_q;
						value_q <= val_q;
					end
					state_q <= S_IDLE;
				end
				S_EXEC: begin
					valid_q  <= 1'b1;
					last_q   <= 1'b1;
					found_q  <= 1'b0;
					value_q  <= '0;
					status_q <= ST_OK;
					unique case (op_q)
						OP_ADD_LINK, OP_ADD_NEURON: begin
							if (full) begin
								status_q <= ST_FULL;
							end else if (sat) begin
								status_q <= ST_SAT;
							end else begin
								found_q     <= 1'b1;
								rec_count_q <= rec_count_q + CNT_W'(1);
								next_inn_q  <= next_inn_q + ID_BITS'(1);
								if (op_q == OP_ADD_NEURON) begin
									value_q    <= next_neu_q;
									next_neu_q <= next_neu_q + ID_BITS'(1);
								end else begin
									value_q <= next_inn_q;
								end
							end
						end
						OP_INIT: begin
							rec_count_q <= '0;
							next_inn_q  <= regs.start_innovation;
							next_neu_q  <= regs.start_neuron;
						end
						OP_FLUSH: begin
							rec_count_q <= '0;
						end
						default: ;
					endcase
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign valid  = valid_q;
	assign found  = found_q;
	assign value  = value_q;
	assign status = status_q;
	assign last   = last_q;

endmodule

// ===== sv/innovation_table_lookup_append_core.sv =====
// ----------------------------------------------------------------------------
// innovation_table_lookup_append_core
// Innovation record table with lookup by (from, to, kind) and append.
//
//   port group   direction  transfer when
//   command      in         start && !busy (op, from_id, to_id, kind, neuron_kind)
//   result       out        valid, one cycle each (found, value, status, last)
//   config       in/out     psel && penable && pwrite (APB, pready tied high)
//
// A lookup reads one record per cycle from the record store, then passes
// through the drain state and the result state; on an empty table it goes
// straight to the result state.
// Adds, init, flush and unused codes pass through the exec state alone.
// Reset empties the table and sets both counters and start registers to 1.
// Results leave through a register one cycle wide; the receiver cannot stall.
// ----------------------------------------------------------------------------
module innovation_table_lookup_append_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [3:0]                     op,
	input  logic [itbl_pkg::ID_BITS-1:0]   from_id,
	input  logic [itbl_pkg::ID_BITS-1:0]   to_id,
	input  logic                           kind,
	input  logic [2:0]                     neuron_kind,
	output logic                           valid,
	output logic                           found,
	output logic [itbl_pkg::ID_BITS-1:0]   value,
	output logic [1:0]                     status,
	output logic                           last,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [itbl_pkg::PADDR_W-1:0]   paddr,
	input  logic [itbl_pkg::PDATA_W-1:0]   pwdata,
	output logic [itbl_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import itbl_pkg::*;

	cfg_regs_t regs;
	mem_req_t  mem_req;
	rec_t      mem_wdata;
	rec_t      mem_rdata;

	itbl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	itbl_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	itbl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.from_id     (from_id),
		.to_id       (to_id),
		.kind        (kind),
		.neuron_kind (neuron_kind),
		.valid       (valid),
		.found       (found),
		.value       (value),
		.status      (status),
		.last        (last),
		.regs        (regs),
		.mem_req     (mem_req),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

endmodule
